>>> design/ssms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_pkg - shared definitions for the shared-store multi-stack
// Operation and status codes, default sizes and the types that travel
// along the cell chain.
// ----------------------------------------------------------------------------
package ssms_pkg;

   // default sizes
   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_NUM_STACKS = 8;
   localparam int DEF_VALUE_BITS = 32;

   // fixed field widths of the channels
   localparam int FUNC_BITS   = 2;
   localparam int ID_BITS     = 3;
   localparam int DATA_BITS   = 32;
   localparam int STATUS_BITS = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_QUERY = 2'd2
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // search result handed from each cell to the one below it
   typedef struct packed {
      logic                 found;   // a match exists at or above this cell
      logic                 second;  // at least two matches exist
      logic [DATA_BITS-1:0] value;   // newest matching value, output format
   } carry_type;

   // commit strobes broadcast to every cell
   typedef struct packed {
      logic push_commit;
      logic pop_commit;
   } cell_cmd_type;

endpackage

>>> design/ssms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_req_if / ssms_rsp_if - request and response channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface ssms_req_if;
   logic                               valid;
   logic                               ready;
   logic [ssms_pkg::FUNC_BITS-1:0]     func;
   logic [ssms_pkg::ID_BITS-1:0]       stack_id;
   logic signed [ssms_pkg::DATA_BITS-1:0] data_in;

   modport source (output valid, func, stack_id, data_in, input ready);
   modport sink   (input valid, func, stack_id, data_in, output ready);
endinterface

interface ssms_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ssms_pkg::DATA_BITS-1:0] data_out;
   logic                               is_empty;
   logic [ssms_pkg::STATUS_BITS-1:0]   status;

   modport source (output valid, data_out, is_empty, status, input ready);
   modport sink   (input valid, data_out, is_empty, status, output ready);
endinterface

>>> design/ssms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_cell - one entry of the shared store
// Holds one tagged value, takes part in the rippling newest-match search
// and shifts down from its upper neighbor when a pop closes a gap.
// ----------------------------------------------------------------------------
module ssms_cell #(
   parameter int INDEX      = 0,
   parameter int VALUE_BITS = ssms_pkg::DEF_VALUE_BITS,
   parameter int TAG_BITS   = 3,
   parameter int CNT_BITS   = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ssms_pkg::cell_cmd_type   cmd,
   input  logic [TAG_BITS-1:0]      tag_sel,
   input  logic [CNT_BITS-1:0]      fill_count,
   input  logic [VALUE_BITS-1:0]    push_value,
   input  logic [VALUE_BITS-1:0]    nbr_value,
   input  logic [TAG_BITS-1:0]      nbr_tag,
   input  ssms_pkg::carry_type      carry_in,
   output logic [VALUE_BITS-1:0]    value_out,
   output logic [TAG_BITS-1:0]      tag_out,
   output ssms_pkg::carry_type      carry_out
);

   localparam int EXT_BITS = (VALUE_BITS > ssms_pkg::DATA_BITS) ? VALUE_BITS
                                                                : ssms_pkg::DATA_BITS;

   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   ssms_pkg::carry_type     carry_ff, carry_in_nxt;
   logic                    occupied;
   logic                    hit;
   logic                    at_fill;
   logic [EXT_BITS-1:0]     value_ext;

   assign occupied = CNT_BITS'(INDEX) < fill_count;
   assign at_fill  = fill_count == CNT_BITS'(INDEX);
   assign hit      = occupied && (tag_ff == tag_sel);

   // stored value in output format: sign-extend, keep low 32 bits
   assign value_ext = EXT_BITS'($signed(value_ff));

   // search step: first match seen from the top is the newest one
   always_comb begin
      carry_in_nxt.found  = carry_in.found | hit;
      carry_in_nxt.second = carry_in.second | (carry_in.found & hit);
      if (hit && !carry_in.found) begin
         carry_in_nxt.value = value_ext[ssms_pkg::DATA_BITS-1:0];
      end else begin
         carry_in_nxt.value = carry_in.value;
      end
   end

   // entry update: append on push, shift down at or above a popped entry
   always_comb begin
      value_in = value_ff;
      tag_in   = tag_ff;
      if (cmd.push_commit && at_fill) begin
         value_in = push_value;
         tag_in   = tag_sel;
      end else if (cmd.pop_commit && !carry_in.found) begin
         value_in = nbr_value;
         tag_in   = nbr_tag;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tag_ff   <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in_nxt;
      end
   end

   assign value_out = value_ff;
   assign tag_out   = tag_ff;
   assign carry_out = carry_ff;

endmodule

>>> design/shared_store_multi_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_store_multi_stack - several LIFO stacks in one shared store
// Top level: request sequencer, fill count, response register and the
// chain of store cells.
// ----------------------------------------------------------------------------
// One operation (push, pop or query) is handled at a time. The request is
// latched on transfer, the newest-match search then ripples down the store
// one cell per cycle, and the result is committed to the store and to the
// response register together; a pop closes the gap in that commit. A
// pending response does not block the next request; only its commit waits
// until the response register is free. Pop or query on an empty stack
// returns status EMPTY, a push into a full store returns status FULL and
// leaves the store unchanged; stack numbers wrap modulo NUM_STACKS.
// ----------------------------------------------------------------------------
module shared_store_multi_stack #(
   parameter int CAPACITY   = ssms_pkg::DEF_CAPACITY,
   parameter int NUM_STACKS = ssms_pkg::DEF_NUM_STACKS,
   parameter int VALUE_BITS = ssms_pkg::DEF_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   ssms_req_if.sink    req_ch,
   ssms_rsp_if.source  rsp_ch
);

   localparam int TAG_BITS = $clog2(NUM_STACKS);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int EXT_BITS = (VALUE_BITS > ssms_pkg::DATA_BITS) ? VALUE_BITS
                                                                : ssms_pkg::DATA_BITS;
   localparam int MOD_BITS = 7;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   logic [CNT_BITS-1:0]               count_ff, count_in;
   logic [CNT_BITS-1:0]               fill_ff, fill_in;
   logic [ssms_pkg::FUNC_BITS-1:0]    func_ff;
   logic [TAG_BITS-1:0]               tag_ff;
   logic [VALUE_BITS-1:0]             value_ff;
   logic                              rsp_valid_ff;
   logic [ssms_pkg::DATA_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic                              rsp_empty_ff, rsp_empty_in;
   logic [ssms_pkg::STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;

   logic                              req_xfer;
   logic                              scan_done;
   logic                              commit;
   logic                              store_full;
   logic                              push_ok;
   logic                              pop_ok;
   logic [TAG_BITS-1:0]               req_tag;
   logic [EXT_BITS-1:0]               din_ext;
   ssms_pkg::cell_cmd_type            cmd;
   ssms_pkg::carry_type               search;

   ssms_pkg::carry_type               carry [0:CAPACITY];
   logic [VALUE_BITS-1:0]             cell_value [0:CAPACITY];
   logic [TAG_BITS-1:0]               cell_tag [0:CAPACITY];

   // stack number modulo NUM_STACKS on a 3-bit id: a few compare/subtracts
   function automatic logic [TAG_BITS-1:0] wrap_id(input logic [ssms_pkg::ID_BITS-1:0] id);
      logic [MOD_BITS-1:0] r;
      r = MOD_BITS'(id);
      for (int k = 0; k < 8; k++) begin
         if (r >= MOD_BITS'(NUM_STACKS)) begin
            r = r - MOD_BITS'(NUM_STACKS);
         end
      end
      return TAG_BITS'(r);
   endfunction

   assign req_tag  = wrap_id(req_ch.stack_id);
   assign din_ext  = EXT_BITS'($signed(req_ch.data_in));

   // handshake and sequencing
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign scan_done    = (state_ff == ST_SCAN) && (count_ff == CNT_BITS'(CAPACITY));
   assign commit       = scan_done && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SCAN;
               count_in = '0;
            end
         end
         ST_SCAN: begin
            if (commit) begin
               state_in = ST_IDLE;
            end else if (!scan_done) begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // latched request
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff  <= req_ch.func;
         tag_ff   <= req_tag;
         value_ff <= din_ext[VALUE_BITS-1:0];
      end
   end

   // outcome of the settled search at the bottom of the chain
   assign search     = carry[0];
   assign store_full = (fill_ff == CNT_BITS'(CAPACITY));

   always_comb begin
      rsp_data_in   = '0;
      rsp_empty_in  = !search.found;
      rsp_status_in = ssms_pkg::STATUS_OK;
      push_ok       = 1'b0;
      pop_ok        = 1'b0;
      case (func_ff)
         ssms_pkg::FUNC_PUSH: begin
            if (store_full) begin
               rsp_status_in = ssms_pkg::STATUS_FULL;
            end else begin
               push_ok      = 1'b1;
               rsp_empty_in = 1'b0;
            end
         end
         ssms_pkg::FUNC_POP: begin
            if (search.found) begin
               pop_ok       = 1'b1;
               rsp_empty_in = !search.second;
            end else begin
               rsp_status_in = ssms_pkg::STATUS_EMPTY;
            end
         end
         ssms_pkg::FUNC_QUERY: begin
            if (search.found) begin
               rsp_data_in = search.value;
            end else begin
               rsp_status_in = ssms_pkg::STATUS_EMPTY;
            end
         end
         default: begin
            // unused code: report emptiness only
         end
      endcase
   end

   assign cmd.push_commit = commit && push_ok;
   assign cmd.pop_commit  = commit && pop_ok;

   // fill count
   always_comb begin
      fill_in = fill_ff;
      if (cmd.push_commit) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop_commit) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = rsp_data_ff;
   assign rsp_ch.is_empty = rsp_empty_ff;
   assign rsp_ch.status   = rsp_status_ff;

   // chain of store cells; the slot above the top cell is empty
   assign carry[CAPACITY]      = '0;
   assign cell_value[CAPACITY] = '0;
   assign cell_tag[CAPACITY]   = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ssms_cell #(
         .INDEX      (i),
         .VALUE_BITS (VALUE_BITS),
         .TAG_BITS   (TAG_BITS),
         .CNT_BITS   (CNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .tag_sel    (tag_ff),
         .fill_count (fill_ff),
         .push_value (value_ff),
         .nbr_value  (cell_value[i+1]),
         .nbr_tag    (cell_tag[i+1]),
         .carry_in   (carry[i+1]),
         .value_out  (cell_value[i]),
         .tag_out    (cell_tag[i]),
         .carry_out  (carry[i])
      );
   end

   // checks
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_BITS'(CAPACITY))
      else $error("fill count beyond capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.push_commit |=> fill_ff == CNT_BITS'($past(fill_ff) + 1'b1))
      else $error("accepted push did not grow the store");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ssms_pkg::STATUS_FULL) |-> store_full)
      else $error("full status while store has room");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ssms_pkg::STATUS_EMPTY) |-> rsp_ch.is_empty)
      else $error("empty status on a non-empty stack");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("response raised without a commit");

endmodule

>>> verif/tb_shared_store_multi_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_store_multi_stack - self-checking bench for the shared-store stacks
// A short directed run covers value extremes, every operation, empty pops and
// queries, the unused operation code and gap closing after a pop. Random runs
// then fill the store to full and drain it under several idle and stall
// patterns. A scoreboard keeps its own copy of the store, predicts every
// response and compares each received one field by field in order.
// ----------------------------------------------------------------------------
module tb_shared_store_multi_stack;

   localparam int CAPACITY        = ssms_pkg::DEF_CAPACITY;
   localparam int NUM_STACKS      = ssms_pkg::DEF_NUM_STACKS;
   localparam int LATENCY         = CAPACITY + 2;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int HOLD_OFF_CYCLES = 1000;
   localparam int PHASE_ITEMS     = 460;
   localparam int PRINT_LIMIT     = 100;

   // operation code the block does not define; must leave the store alone
   localparam logic [ssms_pkg::FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } op_mix_type;

   typedef struct packed {
      logic [ssms_pkg::DATA_BITS-1:0] data_out;
      logic                           is_empty;
      ssms_pkg::status_type           status;
   } answer_type;

   // -------------------------------------------------------------------------
   // Scoreboard: private copy of the tagged store plus the answers still owed
   // -------------------------------------------------------------------------
   class multi_stack_scoreboard;
      logic [ssms_pkg::DATA_BITS-1:0] entry_val [CAPACITY];
      logic [ssms_pkg::ID_BITS-1:0]   entry_tag [CAPACITY];
      int                             fill;
      answer_type                     owed_answers [$];
      int                             mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      // newest entry of a stack, -1 when the stack is empty
      function int newest_index(logic [ssms_pkg::ID_BITS-1:0] tag);
         int i;
         for (i = fill - 1; i >= 0; i--)
            if (entry_tag[i] == tag) return i;
         return -1;
      endfunction

      function int pending();
         return owed_answers.size();
      endfunction

      // stack id that currently holds entries (weighted by depth), else any
      function logic [ssms_pkg::ID_BITS-1:0] pick_stack(bit prefer_filled);
         if (prefer_filled && fill > 0)
            return entry_tag[$urandom_range(fill - 1)];
         return ssms_pkg::ID_BITS'($urandom_range(NUM_STACKS - 1));
      endfunction

      // apply one accepted request to the store copy and queue its answer
      function void note_request(logic [ssms_pkg::FUNC_BITS-1:0] func,
                                 logic [ssms_pkg::ID_BITS-1:0] id,
                                 logic [ssms_pkg::DATA_BITS-1:0] data);
         answer_type                   ans;
         int                           pos;
         int                           k;
         logic [ssms_pkg::ID_BITS-1:0] tag;
         tag          = ssms_pkg::ID_BITS'(id % NUM_STACKS);
         ans.data_out = '0;
         ans.status   = ssms_pkg::STATUS_OK;
         if (func == ssms_pkg::FUNC_PUSH) begin
            if (fill >= CAPACITY) begin
               ans.status = ssms_pkg::STATUS_FULL;
            end else begin
               entry_val[fill] = data;
               entry_tag[fill] = tag;
               fill++;
            end
         end else if (func == ssms_pkg::FUNC_POP) begin
            pos = newest_index(tag);
            if (pos < 0) begin
               ans.status = ssms_pkg::STATUS_EMPTY;
            end else begin
               // close the gap
               for (k = pos; k < fill - 1; k++) begin
                  entry_val[k] = entry_val[k + 1];
                  entry_tag[k] = entry_tag[k + 1];
               end
               fill--;
            end
         end else if (func == ssms_pkg::FUNC_QUERY) begin
            pos = newest_index(tag);
            if (pos < 0) ans.status = ssms_pkg::STATUS_EMPTY;
            else         ans.data_out = entry_val[pos];
         end
         ans.is_empty = (newest_index(tag) < 0);
         owed_answers = {owed_answers, ans};
      endfunction

      task report(string what, logic [ssms_pkg::DATA_BITS-1:0] got,
                  logic [ssms_pkg::DATA_BITS-1:0] want);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("mismatch %s: got %h, expected %h", what, got, want);
      endtask

      task check_answer(logic [ssms_pkg::DATA_BITS-1:0] data_out, logic is_empty,
                        logic [ssms_pkg::STATUS_BITS-1:0] status);
         answer_type ans;
         if (owed_answers.size() == 0) begin
            report("unexpected response, data_out", data_out, '0);
            return;
         end
         ans = owed_answers.pop_front();
         if (data_out !== ans.data_out) report("data_out", data_out, ans.data_out);
         if (is_empty !== ans.is_empty)
            report("is_empty", ssms_pkg::DATA_BITS'(is_empty),
                   ssms_pkg::DATA_BITS'(ans.is_empty));
         if (status !== ans.status)
            report("status", ssms_pkg::DATA_BITS'(status),
                   ssms_pkg::DATA_BITS'(ans.status));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          long_gaps      = 1'b0;
   bit          hold_request   = 1'b0;
   bit          rx_hold        = 1'b0;
   int unsigned cycle_count    = 0;

   multi_stack_scoreboard sb = new();

   ssms_req_if req_ch ();
   ssms_rsp_if rsp_ch ();

   shared_store_multi_stack i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Response side: ready changes on the falling edge, transfers seen on rising
   // -------------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = !rx_hold && ($urandom_range(99) >= recv_stall_pct);
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_answer(rsp_ch.data_out, rsp_ch.is_empty, rsp_ch.status);
      end
   end

   // long receiver hold-off, counted here so the sender keeps offering
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rx_hold      = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rx_hold = 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // entered and left at a falling edge
   task automatic send_item(input logic [ssms_pkg::FUNC_BITS-1:0] func,
                            input logic [ssms_pkg::ID_BITS-1:0] id,
                            input logic [ssms_pkg::DATA_BITS-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      // occasional long gap so idle time lands deep inside the search
      if (long_gaps && $urandom_range(15) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(LATENCY)) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.func     = func;
      req_ch.stack_id = id;
      req_ch.data_in  = data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(func, id, data);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic send_random(input op_mix_type mix);
      int                             roll;
      int                             push_pct;
      int                             pop_pct;
      logic [ssms_pkg::FUNC_BITS-1:0] func;
      logic [ssms_pkg::ID_BITS-1:0]   id;
      logic [ssms_pkg::DATA_BITS-1:0] data;
      case (mix)
         MIX_FILL: begin
            push_pct = 75;
            pop_pct  = 10;
         end
         MIX_DRAIN: begin
            push_pct = 15;
            pop_pct  = 70;
         end
         default: begin
            push_pct = 40;
            pop_pct  = 35;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < 2)                           func = FUNC_UNUSED;
      else if (roll < 2 + push_pct)           func = ssms_pkg::FUNC_PUSH;
      else if (roll < 2 + push_pct + pop_pct) func = ssms_pkg::FUNC_POP;
      else                                    func = ssms_pkg::FUNC_QUERY;
      if (func == ssms_pkg::FUNC_PUSH)
         id = ssms_pkg::ID_BITS'($urandom_range(NUM_STACKS - 1));
      else
         id = sb.pick_stack($urandom_range(3) != 0);
      case ($urandom_range(11))
         0:       data = 32'h8000_0000;
         1:       data = 32'h7fff_ffff;
         2:       data = '0;
         3:       data = '1;
         default: data = $urandom;
      endcase
      send_item(func, id, data);
   endtask

   // one idling pattern: fill to full, mix, drain to empty, mix
   task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
      int n;
      // pause until every owed answer has arrived
      while (sb.pending() != 0) @(negedge clock);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      long_gaps      = (idle_pct > 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (with_hold && n == 300) hold_request = 1'b1;
         if (n < 130)      send_random(MIX_FILL);
         else if (n < 220) send_random(MIX_EVEN);
         else if (n < 370) send_random(MIX_DRAIN);
         else              send_random(MIX_EVEN);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.func     = ssms_pkg::FUNC_PUSH;
      req_ch.stack_id = '0;
      req_ch.data_in  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty cases, extremes, unused code, gap closing
      send_item(ssms_pkg::FUNC_QUERY, 3'd3, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_POP,   3'd3, 32'hffff_ffff);
      send_item(FUNC_UNUSED,          3'd5, 32'h1234_5678);
      send_item(ssms_pkg::FUNC_PUSH,  3'd0, 32'h8000_0000);
      send_item(ssms_pkg::FUNC_PUSH,  3'd7, 32'h7fff_ffff);
      send_item(ssms_pkg::FUNC_PUSH,  3'd7, 32'hffff_ffff);
      send_item(ssms_pkg::FUNC_QUERY, 3'd7, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_QUERY, 3'd0, 32'h0000_0000);
      send_item(FUNC_UNUSED,          3'd7, 32'hdead_beef);
      send_item(ssms_pkg::FUNC_POP,   3'd7, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_QUERY, 3'd7, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_POP,   3'd7, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_POP,   3'd7, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_QUERY, 3'd7, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_PUSH,  3'd1, 32'h0000_0001);
      send_item(ssms_pkg::FUNC_PUSH,  3'd2, 32'haaaa_aaaa);
      send_item(ssms_pkg::FUNC_PUSH,  3'd3, 32'h5555_5555);
      send_item(ssms_pkg::FUNC_POP,   3'd1, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_QUERY, 3'd2, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_QUERY, 3'd3, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_POP,   3'd0, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_QUERY, 3'd0, 32'h0000_0000);
      send_item(ssms_pkg::FUNC_QUERY, 3'd2, 32'h0000_0000);

      // random: no idling (with the long hold-off), sender idle, receiver
      // stalling, both
      run_phase(0, 0, 1'b1);
      run_phase(78, 0, 1'b0);
      run_phase(0, 78, 1'b0);
      run_phase(33, 33, 1'b0);

      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
